// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define BB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define BB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bblur_pkg.sv
`default_nettype none

package bblur_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int Q_DEPTH_DEF   = 8;

    localparam int CH_W       = 8;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    // wide enough for any size compare (widths up to 2047, heights up to 8191)
    localparam int EXT_W      = 14;
    localparam int SUM_W      = 12;

    // x / 9 == (x * 3641) >> 15 for all x below 2296
    localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
    localparam int               DIV9_SHIFT = 15;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic            start_of_frame;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0]      out_red;
        logic [CH_W-1:0]      out_green;
        logic [CH_W-1:0]      out_blue;
        logic [COL_OUT_W-1:0] out_col;
        logic [ROW_W-1:0]     out_row;
        logic                 is_border;
        logic                 last_of_run;
    } t_out;

    // per-pixel classification carried down the front pipeline
    typedef struct packed {
        t_rgb                 pix;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 avg;
        logic                 border;
    } t_tag;

    // queue entry: everything the back end needs for up to two results
    typedef struct packed {
        t_tag tag;
        t_rgb mean;
    } t_job;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_bk_state;

endpackage

`default_nettype wire

// File: rtl/bblur_line_buf.sv
`default_nettype none

module bblur_line_buf #(
    parameter int DEPTH = bblur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_acc,
    input  wire logic [$clog2(DEPTH)-1:0]     i_addr,
    input  wire bblur_pkg::t_rgb              i_pix,
    input  wire logic                         i_wr1_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_wr1_addr,
    input  wire bblur_pkg::t_rgb              i_wr1_data,
    output      bblur_pkg::t_rgb              o_above,
    output      bblur_pkg::t_rgb              o_above2
);

    localparam int AW = $clog2(DEPTH);

    bblur_pkg::t_rgb r_bank0 [DEPTH];
    bblur_pkg::t_rgb r_bank1 [DEPTH];
    bblur_pkg::t_rgb r_rd0;
    bblur_pkg::t_rgb r_rd1;
    bblur_pkg::t_rgb r_byp_data;
    logic            r_byp;

    // bank 0: previous row. Read-before-write at the same address.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd0          <= r_bank0[i_addr];
            r_bank0[i_addr] <= i_pix;
        end
    end

    // bank 1: row before that, written in the cycle after the read of bank 0
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd1 <= r_bank1[i_addr];
        end
        if (i_wr1_en) begin
            r_bank1[i_wr1_addr] <= i_wr1_data;
        end
    end

    // same-cycle write to bank 1 at the read address: take the new data
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_byp      <= i_wr1_en && (i_wr1_addr == i_addr);
            r_byp_data <= i_wr1_data;
        end
    end

    assign o_above  = r_rd0;
    assign o_above2 = r_byp ? r_byp_data : r_rd1;

endmodule

`default_nettype wire

// File: rtl/bblur_queue.sv
`default_nettype none

`include "assert_macros.svh"

module bblur_queue #(
    parameter int DEPTH = bblur_pkg::Q_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire bblur_pkg::t_job            i_job,
    input  wire logic                       i_pop,
    output      logic                       o_valid,
    output      bblur_pkg::t_job            o_head,
    output      logic [$clog2(DEPTH):0]     o_count
);

    localparam int AW = $clog2(DEPTH);

    bblur_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // front end's credit check must keep the queue from overflowing
    `BB_ASSERT(a_no_overflow, i_clk, i_rst_n, (i_push && (r_count == (AW+1)'(DEPTH))) |-> i_pop, "queue overflow")
    `BB_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from empty queue")

endmodule

`default_nettype wire

// File: rtl/bblur_back.sv
`default_nettype none

`include "assert_macros.svh"

module bblur_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_head_valid,
    input  wire bblur_pkg::t_job     i_head,
    output      logic                o_pop,
    output      logic                o_valid,
    output      bblur_pkg::t_out     o_data,
    input  wire logic                i_stall
);

    bblur_pkg::t_bk_state r_state;
    bblur_pkg::t_bk_state n_state;
    bblur_pkg::t_out      r_out_data;
    logic                 r_out_valid;
    bblur_pkg::t_out      w_res;
    logic                 w_ld;
    logic                 w_two;

    assign w_ld  = i_head_valid && (!r_out_valid || !i_stall);
    assign w_two = i_head.tag.avg && i_head.tag.border;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bblur_pkg::BK_FIRST: begin
                if (w_ld && w_two) n_state = bblur_pkg::BK_SECOND;
            end
            bblur_pkg::BK_SECOND: begin
                if (w_ld) n_state = bblur_pkg::BK_FIRST;
            end
            default: n_state = bblur_pkg::BK_FIRST;
        endcase
    end

    // result selection and pop
    always_comb begin
        w_res.out_red     = i_head.tag.pix.red;
        w_res.out_green   = i_head.tag.pix.green;
        w_res.out_blue    = i_head.tag.pix.blue;
        w_res.out_col     = i_head.tag.col;
        w_res.out_row     = i_head.tag.row;
        w_res.is_border   = 1'b1;
        w_res.last_of_run = 1'b1;
        o_pop             = w_ld;
        case (r_state)
            bblur_pkg::BK_FIRST: begin
                if (i_head.tag.avg) begin
                    // averaged pixel sits one up and one left
                    w_res.out_red     = i_head.mean.red;
                    w_res.out_green   = i_head.mean.green;
                    w_res.out_blue    = i_head.mean.blue;
                    w_res.out_col     = i_head.tag.col - 1'b1;
                    w_res.out_row     = i_head.tag.row - 1'b1;
                    w_res.is_border   = 1'b0;
                    w_res.last_of_run = !i_head.tag.border;
                    o_pop             = w_ld && !i_head.tag.border;
                end
            end
            bblur_pkg::BK_SECOND: begin
                o_pop = w_ld;
            end
            default: begin
                o_pop = w_ld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bblur_pkg::BK_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_out_data <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    `BB_ASSERT(a_second_has_both, i_clk, i_rst_n, (r_state == bblur_pkg::BK_SECOND) |-> (i_head_valid && i_head.tag.avg && i_head.tag.border), "second result without a two-result entry")
    `BB_ASSERT_NEXT(a_avg_then_border, i_clk, i_rst_n, w_ld && !w_res.last_of_run, (r_state == bblur_pkg::BK_SECOND) && i_head_valid, "border result lost after averaged one")

endmodule

`default_nettype wire

// File: rtl/bblur_front.sv
`default_nettype none

`include "assert_macros.svh"

module bblur_front #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF,
    parameter int Q_DEPTH   = bblur_pkg::Q_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire bblur_pkg::t_in                       i_data,
    output      logic                                 o_stall,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic [$clog2(Q_DEPTH):0]             i_q_count,
    output      logic                                 o_push,
    output      bblur_pkg::t_job                      o_job
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EXT_W = bblur_pkg::EXT_W;
    localparam int ROW_W = bblur_pkg::ROW_W;
    localparam int SUM_W = bblur_pkg::SUM_W;
    localparam int CH_W  = bblur_pkg::CH_W;
    localparam int CNT_W = $clog2(Q_DEPTH) + 2;
    localparam logic [EXT_W-1:0] MAXW_X = EXT_W'(MAX_WIDTH);
    localparam logic [EXT_W-1:0] MAXH_X = EXT_W'(bblur_pkg::MAX_HEIGHT);

    // configuration
    logic [bblur_pkg::FW_W-1:0] r_frame_width;
    logic [bblur_pkg::FH_W-1:0] r_frame_height;

    // position of the next pixel
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    // pipeline
    logic              r_s1_valid;
    logic [CW-1:0]     r_s1_addr;
    bblur_pkg::t_tag   r_s1_tag;
    logic              r_s2_valid;
    bblur_pkg::t_tag   r_s2_tag;
    logic              r_s3_valid;
    bblur_pkg::t_tag   r_s3_tag;
    logic [SUM_W-1:0]  r_s3_sum_r;
    logic [SUM_W-1:0]  r_s3_sum_g;
    logic [SUM_W-1:0]  r_s3_sum_b;

    bblur_pkg::t_rgb   r_win [3][3];

    logic              w_acc;
    logic [EXT_W-1:0]  w_fw;
    logic [EXT_W-1:0]  w_fh;
    logic [EXT_W-1:0]  w_w;
    logic [EXT_W-1:0]  w_h;
    logic [EXT_W-1:0]  w_c_in;
    logic [EXT_W-1:0]  w_c;
    logic [EXT_W-1:0]  w_r;
    logic              w_last_col;
    logic              w_last_row;
    logic              w_border;
    logic              w_avg;
    bblur_pkg::t_rgb   w_pix;
    bblur_pkg::t_rgb   w_above;
    bblur_pkg::t_rgb   w_above2;
    logic [SUM_W-1:0]  w_sum_r;
    logic [SUM_W-1:0]  w_sum_g;
    logic [SUM_W-1:0]  w_sum_b;
    logic [2*SUM_W-1:0] w_prod_r;
    logic [2*SUM_W-1:0] w_prod_g;
    logic [2*SUM_W-1:0] w_prod_b;
    logic [CNT_W-1:0]  w_total;

    // credit: queue entries plus items still in the pipeline
    assign w_total = CNT_W'(i_q_count) + CNT_W'(r_s1_valid) + CNT_W'(r_s2_valid)
                   + CNT_W'(r_s3_valid);
    assign o_stall = (w_total >= CNT_W'(Q_DEPTH));
    assign w_acc   = i_valid && !o_stall;

    // classify the incoming pixel
    always_comb begin
        w_fw = EXT_W'(r_frame_width);
        w_fh = EXT_W'(r_frame_height);
        w_w  = (w_fw == '0) ? EXT_W'(1) : ((w_fw > MAXW_X) ? MAXW_X : w_fw);
        w_h  = (w_fh == '0) ? EXT_W'(1) : ((w_fh > MAXH_X) ? MAXH_X : w_fh);

        w_c_in = i_data.start_of_frame ? '0 : EXT_W'(r_col);
        w_r    = i_data.start_of_frame ? '0 : EXT_W'(r_row);
        w_c    = (w_c_in >= w_w) ? (w_w - 1'b1) : w_c_in;

        w_last_col = (w_c + 1'b1 >= w_w);
        w_last_row = (w_r + 1'b1 >= w_h);
        w_border   = (w_c == '0) || (w_r == '0) || w_last_col || w_last_row;
        w_avg      = (w_c >= EXT_W'(2)) && (w_r >= EXT_W'(2)) && (w_r <= w_h - 1'b1);

        w_pix.red   = i_data.in_red;
        w_pix.green = i_data.in_green;
        w_pix.blue  = i_data.in_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bblur_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bblur_pkg::FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bblur_pkg::CFG_FRAME_WIDTH:
                        r_frame_width <= i_cfg_wdata[bblur_pkg::FW_W-1:0];
                    bblur_pkg::CFG_FRAME_HEIGHT:
                        r_frame_height <= i_cfg_wdata[bblur_pkg::FH_W-1:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : ROW_W'(w_r + 1'b1);
                end else begin
                    r_col <= CW'(w_c + 1'b1);
                    r_row <= ROW_W'(w_r);
                end
            end
            r_s1_valid <= w_acc;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    bblur_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_acc      (w_acc),
        .i_addr     (CW'(w_c)),
        .i_pix      (w_pix),
        .i_wr1_en   (r_s1_valid),
        .i_wr1_addr (r_s1_addr),
        .i_wr1_data (w_above),
        .o_above    (w_above),
        .o_above2   (w_above2)
    );

    // stage 1 tag
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_addr       <= CW'(w_c);
            r_s1_tag.pix    <= w_pix;
            r_s1_tag.col    <= bblur_pkg::COL_OUT_W'(w_c);
            r_s1_tag.row    <= ROW_W'(w_r);
            r_s1_tag.avg    <= w_avg;
            r_s1_tag.border <= w_border;
        end
    end

    // window shifts once per pixel, new column from the line store
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= w_above2;
            r_win[1][2] <= w_above;
            r_win[2][2] <= r_s1_tag.pix;
        end
    end

    // stage 2: channel sums of the window
    always_comb begin
        w_sum_r = '0;
        w_sum_g = '0;
        w_sum_b = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_sum_r = w_sum_r + SUM_W'(r_win[i][j].red);
                w_sum_g = w_sum_g + SUM_W'(r_win[i][j].green);
                w_sum_b = w_sum_b + SUM_W'(r_win[i][j].blue);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_tag   <= r_s1_tag;
        r_s3_tag   <= r_s2_tag;
        r_s3_sum_r <= w_sum_r;
        r_s3_sum_g <= w_sum_g;
        r_s3_sum_b <= w_sum_b;
    end

    // stage 3: divide by 9 through reciprocal multiply, result lands in the queue
    assign w_prod_r = r_s3_sum_r * bblur_pkg::DIV9_MUL;
    assign w_prod_g = r_s3_sum_g * bblur_pkg::DIV9_MUL;
    assign w_prod_b = r_s3_sum_b * bblur_pkg::DIV9_MUL;

    assign o_push           = r_s3_valid && (r_s3_tag.avg || r_s3_tag.border);
    assign o_job.tag        = r_s3_tag;
    assign o_job.mean.red   = w_prod_r[bblur_pkg::DIV9_SHIFT +: CH_W];
    assign o_job.mean.green = w_prod_g[bblur_pkg::DIV9_SHIFT +: CH_W];
    assign o_job.mean.blue  = w_prod_b[bblur_pkg::DIV9_SHIFT +: CH_W];

    `BB_ASSERT(a_credit_bound, i_clk, i_rst_n, w_total <= CNT_W'(Q_DEPTH), "more items in flight than queue space")
    `BB_ASSERT(a_avg_interior, i_clk, i_rst_n, (r_s1_valid && r_s1_tag.avg) |-> ((r_s1_tag.row >= ROW_W'(2)) && (r_s1_addr >= CW'(2))), "averaged pixel too close to the top or left edge")

endmodule

`default_nettype wire

// File: rtl/box_blur_3x3_rgb_unit.sv
// 3x3 box blur for an RGB pixel stream. Pixels come in raster order; the frame
// size is set through the write port (index 0: frame width, index 1: frame
// height) only while the block is idle, a rule for the user that the block does
// not enforce. Border pixels leave unchanged with is_border set; every interior
// pixel leaves as the truncated per-channel mean of its 3x3 neighborhood once
// its lower-right neighbor has arrived, so a request at the end of a row or in
// the last row, from column 2 and row 2 on, yields two results: the averaged
// one first, then the border one. start_of_frame, or the last pixel of a frame,
// sends the position back to column 0, row 0. The block accepts one request
// per clock unless stalled. The output side delivers one result per clock while
// i_stall is low, so requests that yield two results hold the input below that
// rate; elsewhere it is one per clock. Requests stall when the result queue
// entries plus the items in the three pipeline stages ahead of it reach Q_DEPTH
// (eight by default). The line store is two banks of MAX_WIDTH x 24 bits that
// need no clear after reset; the block is ready as soon as reset is released.

`default_nettype none

module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF,
    parameter int Q_DEPTH   = bblur_pkg::Q_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // pixel requests
    input  wire logic                              i_valid,
    input  wire bblur_pkg::t_in                    i_data,
    output      logic                              o_stall,
    // results
    output      logic                              o_valid,
    output      bblur_pkg::t_out                   o_data,
    input  wire logic                              i_stall,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic                        w_push;
    bblur_pkg::t_job             w_job;
    logic                        w_pop;
    logic                        w_head_valid;
    bblur_pkg::t_job             w_head;
    logic [$clog2(Q_DEPTH):0]    w_q_count;

    // Front: position counters, border/interior classification, line store,
    // window and the sum / divide-by-9 pipeline (fixed three stages).
    bblur_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .Q_DEPTH   (Q_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_count   (w_q_count),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    // Queue of finished pixels; one entry holds up to two results.
    bblur_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head),
        .o_count (w_q_count)
    );

    // Back: splits each entry into its results, registered output stage.
    bblur_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .i_stall      (i_stall)
    );

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bblur_pkg::*;

    localparam int MAXW         = MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Settling margin: requests that produce no result can still be in the
    // pipeline ahead of the eight-deep result queue.
    localparam int SETTLE_TICKS = 24;
    localparam int RANDOM_ITEMS = 900;
    localparam int MAX_PRINTS   = 40;

    // ---------------------------------------------------------------
    // Clock, reset, DUT
    // ---------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  i_valid = 1'b0;
    t_in                   i_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out                  o_data;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    box_blur_3x3_rgb_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ---------------------------------------------------------------
    // Bookkeeping
    // ---------------------------------------------------------------
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 0;
    bit          idle_on = 1'b1;     // random gaps on both sides when set
    int unsigned stall_left = 0;     // stall cycles still to apply on the result side

    // ---------------------------------------------------------------
    // Blur predictor state: frame registers, two row banks (bank 0 is the
    // row above, bank 1 the row above that), 3x3 window, position.
    // ---------------------------------------------------------------
    logic [FW_W-1:0] frame_w_reg = FRAME_WIDTH_RST;
    logic [FH_W-1:0] frame_h_reg = FRAME_HEIGHT_RST;
    t_rgb            row_bank [2][MAXW];
    t_rgb            win [3][3] = '{default: '0};
    int unsigned     col_pos = 0;
    int unsigned     row_pos = 0;
    t_out            blurred_due [$];   // expected results, oldest first

    task automatic predict_blur(input t_in px);
        int unsigned w, h, c, r, sr, sg, sb;
        t_rgb        pix, up1, up2;
        bit          avg, border;
        t_out        res;
        w = frame_w_reg;
        h = frame_h_reg;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;

        if (px.start_of_frame) begin
            col_pos = 0;
            row_pos = 0;
        end
        // width shrunk under a running row: clamp onto the last column
        if (col_pos >= w) col_pos = w - 1;
        c = col_pos;
        r = row_pos;

        pix = {px.in_red, px.in_green, px.in_blue};
        up1 = row_bank[0][c];
        up2 = row_bank[1][c];
        row_bank[1][c] = up1;
        row_bank[0][c] = pix;

        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = pix;

        border = (c == 0 || r == 0 || c + 1 >= w || r + 1 >= h);
        avg    = (c >= 2 && r >= 2 && c <= w - 1 && r <= h - 1);

        // averaged pixel (centre one up, one left) goes out ahead of the border one
        if (avg) begin
            sr = 0;
            sg = 0;
            sb = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    sr += win[i][j].red;
                    sg += win[i][j].green;
                    sb += win[i][j].blue;
                end
            end
            res.out_red     = sr / 9;
            res.out_green   = sg / 9;
            res.out_blue    = sb / 9;
            res.out_col     = c - 1;
            res.out_row     = r - 1;
            res.is_border   = 1'b0;
            res.last_of_run = !border;
            blurred_due.push_back(res);
        end
        if (border) begin
            res.out_red     = pix.red;
            res.out_green   = pix.green;
            res.out_blue    = pix.blue;
            res.out_col     = c;
            res.out_row     = r;
            res.is_border   = 1'b1;
            res.last_of_run = 1'b1;
            blurred_due.push_back(res);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // ---------------------------------------------------------------
    // Reporting and result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic cmp_field(input string name, input logic [11:0] got,
                             input logic [11:0] want, input t_out exp_px);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h (pixel col %0d row %0d)",
                                      name, got, want, exp_px.out_col, exp_px.out_row));
    endtask

    task automatic check_blurred(input t_out got);
        t_out want;
        if (blurred_due.size() == 0) begin
            report_mismatch($sformatf("result col %0d row %0d with nothing pending",
                                      got.out_col, got.out_row));
            return;
        end
        want = blurred_due.pop_front();
        cmp_field("red",    got.out_red,     want.out_red,     want);
        cmp_field("green",  got.out_green,   want.out_green,   want);
        cmp_field("blue",   got.out_blue,    want.out_blue,    want);
        cmp_field("col",    got.out_col,     want.out_col,     want);
        cmp_field("row",    got.out_row,     want.out_row,     want);
        cmp_field("border", got.is_border,   want.is_border,   want);
        cmp_field("last",   got.last_of_run, want.last_of_run, want);
        results_checked++;
    endtask

    // Result side: check each accepted result, then hold stall for a drawn
    // number of cycles before taking the next one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                check_blurred(o_data);
                stall_left = idle_on ? $urandom_range(0, 4) : 0;
            end else if (i_stall && stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     blurred_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Both registers are written back to back; write enable stays high
    // across the pair so it is never dropped and raised in one step.
    task automatic set_frame(input logic [CFG_DATA_W-1:0] w_word,
                             input logic [CFG_DATA_W-1:0] h_word);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FRAME_WIDTH;
        i_cfg_wdata <= w_word;
        @(posedge i_clk);
        frame_w_reg = w_word[FW_W-1:0];
        i_cfg_idx   <= CFG_FRAME_HEIGHT;
        i_cfg_wdata <= h_word;
        @(posedge i_clk);
        frame_h_reg = h_word[FH_W-1:0];
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pixel(input t_in px);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        do @(posedge i_clk); while (o_stall);
        predict_blur(px);
        requests_sent++;
    endtask

    // Drop valid, let every pending result come back, then give the block
    // time to finish requests that produce no result.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (blurred_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic t_in rand_pixel(input bit sof);
        t_in px;
        px.in_red         = pick_level();
        px.in_green       = pick_level();
        px.in_blue        = pick_level();
        px.start_of_frame = sof;
        return px;
    endfunction

    function automatic t_in flat_pixel(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input bit sof);
        return {r, g, b, sof};
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // 3x3 frame: a single interior pixel, emitted on the last request
    // together with that request's border result. Second frame wraps in
    // without start_of_frame. Then width/height 0 (acting as 1).
    task automatic test_smallest_frame();
        set_frame(13'd3, 13'd3);
        idle_on = 1'b1;
        for (int i = 0; i < 9; i++) send_pixel(flat_pixel(8'hff, 8'hff, 8'hff, i == 0));
        for (int i = 0; i < 9; i++)
            send_pixel(flat_pixel(8'hff, 8'h00, (i % 2) ? 8'hff : 8'h00, 1'b0));
        wait_idle();
        // upper width bits fall outside the 11-bit register: width reads as 0
        set_frame(13'h1800, 13'd0);
        send_pixel(flat_pixel(8'h00, 8'hff, 8'h00, 1'b0));
        send_pixel(flat_pixel(8'hff, 8'h00, 8'hff, 1'b1));
        send_pixel(flat_pixel(8'h5a, 8'ha5, 8'h3c, 1'b0));
        wait_idle();
    endtask

    // Width beyond MAX_WIDTH saturates; run into the third row so the
    // averaging path works at full width.
    task automatic test_max_width();
        set_frame(13'h1fff, 13'd3);
        idle_on = 1'b0;
        for (int i = 0; i < 2 * MAXW + 6; i++) send_pixel(rand_pixel(i == 0));
        wait_idle();
    endtask

    // Height beyond 4096 saturates; one-pixel rows reach the last row and wrap.
    task automatic test_max_height();
        set_frame(13'd1, 13'h1fff);
        idle_on = 1'b0;
        for (int i = 0; i < MAX_HEIGHT + 3; i++) send_pixel(rand_pixel(i == 0));
        wait_idle();
    endtask

    // Frame size changed while a frame is in progress: shrinking width
    // clamps the column, a row past the new last row ends the frame.
    task automatic test_resize_mid_frame();
        idle_on = 1'b1;
        set_frame(13'd8, 13'd6);
        for (int i = 0; i < 8 * 3 + 4; i++) send_pixel(rand_pixel(i == 0));
        wait_idle();
        set_frame(13'd3, 13'd3);
        for (int i = 0; i < 12; i++) send_pixel(rand_pixel(1'b0));
        wait_idle();

        set_frame(13'd9, 13'd9);
        for (int i = 0; i < 9 * 4 + 6; i++) send_pixel(rand_pixel(i == 0));
        wait_idle();
        set_frame(13'd9, 13'd5);   // current row becomes the last one
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel(1'b0));
        wait_idle();
        set_frame(13'd6, 13'd12);  // narrower and taller, no restart
        for (int i = 0; i < 30; i++) send_pixel(rand_pixel(1'b0));
        wait_idle();
    endtask

    // Random frame sizes, mostly complete frames with random content; some
    // frames are cut short, overrun and wrap, restart midway, or start
    // without the start flag.
    task automatic test_random_frames(input int unsigned n_items);
        int unsigned stop_at, w, h, area, nframes, kind, n, restart_at;
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_frame(w, h);
            idle_on = ($urandom_range(0, 4) != 0);
            area    = ((w < 1) ? 1 : w) * ((h < 1) ? 1 : h);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                kind       = $urandom_range(0, 9);
                n          = area;
                restart_at = area + area + 1;   // no restart by default
                case (kind)
                    0: n = $urandom_range(1, area);
                    1: n = area + $urandom_range(1, area);
                    2: restart_at = $urandom_range(1, area);
                    default: ;
                endcase
                // first frame after a size change always restarts
                for (int i = 0; i < n; i++)
                    send_pixel(rand_pixel((i == 0 && (f == 0 || kind != 3)) ||
                                          i == restart_at));
            end
            wait_idle();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_smallest_frame();
        test_resize_mid_frame();
        test_max_width();
        test_max_height();
        test_random_frames(RANDOM_ITEMS);

        wait_idle();
        $display("covered %0d pixel requests over %0d frame sizes (3x3 to saturated)",
                 requests_sent, settings_used);
        $display("checked %0d results, %0d mismatches", results_checked, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
